// File: sv/bvls_pkg.sv
// ----------------------------------------------------------------------------
// bvls_pkg: shared definitions for the bencode value length scanner
// parse mode codes, status codes, delimiter bytes and the control struct
// ----------------------------------------------------------------------------
`default_nettype none

package bvls_pkg;

  // parse modes
  localparam logic [2:0] MODE_VALUE_START = 3'd0;
  localparam logic [2:0] MODE_INT_BODY    = 3'd1;
  localparam logic [2:0] MODE_LEN_DIGITS  = 3'd2;
  localparam logic [2:0] MODE_STR_BODY    = 3'd3;
  localparam logic [2:0] MODE_DONE        = 3'd4;
  localparam logic [2:0] MODE_BAD_TYPE    = 3'd5;
  localparam logic [2:0] MODE_OVERFLOW    = 3'd6;

  // result status codes
  localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
  localparam logic [1:0] STATUS_BAD_TYPE  = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

  // delimiter bytes
  localparam logic [7:0] CHAR_I     = 8'h69;
  localparam logic [7:0] CHAR_E     = 8'h65;
  localparam logic [7:0] CHAR_L     = 8'h6C;
  localparam logic [7:0] CHAR_D     = 8'h64;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned RADIX = 10;

  typedef struct packed {
    logic [2:0] mode;
    logic       answer_given;
  } scan_ctl_t;

endpackage

`default_nettype wire

// File: sv/bvls_if.sv
// ----------------------------------------------------------------------------
// bvls channel interfaces
// byte input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface bvls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bvls_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_length;
  logic [1:0]  status;

  modport source (output valid, output value_length, output status, input ready);
  modport sink (input valid, input value_length, input status, output ready);
endinterface

`default_nettype wire

// File: sv/bvls_next.sv
// ----------------------------------------------------------------------------
// bvls_next: per-byte scanner update
// next parse state and result fields for one payload byte
// ----------------------------------------------------------------------------
`default_nettype none

module bvls_next #(
  parameter int MAX_DEPTH = 64,
  parameter int LEN_BITS  = 32,
  parameter int DEPTH_W   = 7
) (
  input  wire bvls_pkg::scan_ctl_t ctl,
  input  wire logic [DEPTH_W-1:0]  depth,
  input  wire logic [LEN_BITS-1:0] slen,
  input  wire logic [LEN_BITS-1:0] pos,
  input  wire logic [7:0]          data_byte,
  output bvls_pkg::scan_ctl_t      ctl_next,
  output logic [DEPTH_W-1:0]       depth_next,
  output logic [LEN_BITS-1:0]      slen_next,
  output logic [LEN_BITS-1:0]      pos_next,
  output logic [31:0]              value_length,
  output logic [1:0]               status
);

  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

  logic                  is_digit;
  logic [3:0]            digit;
  logic [LEN_BITS-1:0]   pos_inc;
  logic [LEN_BITS+3:0]   slen_ext;
  logic [LEN_BITS+3:0]   slen_x10;
  logic                  slen_x10_ovf;
  logic [LEN_BITS:0]     end_sum;
  logic [LEN_BITS-1:0]   slen_dec;
  logic [LEN_BITS+31:0]  pos_wide;
  logic                  finish;
  logic [DEPTH_W-1:0]    finish_depth;

  assign is_digit     = (data_byte >= bvls_pkg::CHAR_ZERO) && (data_byte <= bvls_pkg::CHAR_NINE);
  assign digit        = data_byte[3:0];
  assign pos_inc      = pos + LEN_BITS'(1);
  // times ten plus the digit, as two shifts and two adds
  assign slen_ext     = {4'b0, slen};
  assign slen_x10     = (slen_ext << 3) + (slen_ext << 1) + (LEN_BITS + 4)'(digit);
  assign slen_x10_ovf = |slen_x10[LEN_BITS+3:LEN_BITS];
  // string end offset must stay inside the length range
  assign end_sum      = {1'b0, slen} + {1'b0, pos_inc};
  assign slen_dec     = (slen == '0) ? slen : slen - LEN_BITS'(1);

  always_comb begin
    ctl_next     = ctl;
    depth_next   = depth;
    slen_next    = slen;
    pos_next     = pos;
    finish       = 1'b0;
    finish_depth = depth;
    if (!ctl.answer_given) begin
      if (&pos) begin
        ctl_next.mode         = bvls_pkg::MODE_OVERFLOW;
        ctl_next.answer_given = 1'b1;
      end else begin
        pos_next = pos_inc;
        unique case (ctl.mode)
          bvls_pkg::MODE_VALUE_START: begin
            if (data_byte == bvls_pkg::CHAR_E) begin
              if (depth == '0) begin
                ctl_next.mode         = bvls_pkg::MODE_BAD_TYPE;
                ctl_next.answer_given = 1'b1;
              end else begin
                depth_next   = depth - DEPTH_W'(1);
                finish_depth = depth - DEPTH_W'(1);
                finish       = 1'b1;
              end
            end else if (data_byte == bvls_pkg::CHAR_I) begin
              ctl_next.mode = bvls_pkg::MODE_INT_BODY;
            end else if (data_byte == bvls_pkg::CHAR_L || data_byte == bvls_pkg::CHAR_D) begin
              if (depth >= DEPTH_LIMIT) begin
                ctl_next.mode         = bvls_pkg::MODE_OVERFLOW;
                ctl_next.answer_given = 1'b1;
              end else begin
                depth_next = depth + DEPTH_W'(1);
              end
            end else if (is_digit) begin
              slen_next     = LEN_BITS'(digit);
              ctl_next.mode = bvls_pkg::MODE_LEN_DIGITS;
            end else begin
              ctl_next.mode         = bvls_pkg::MODE_BAD_TYPE;
              ctl_next.answer_given = 1'b1;
            end
          end
          bvls_pkg::MODE_INT_BODY: begin
            if (data_byte == bvls_pkg::CHAR_E) begin
              finish = 1'b1;
            end
          end
          bvls_pkg::MODE_LEN_DIGITS: begin
            if (data_byte == bvls_pkg::CHAR_COLON) begin
              if (end_sum[LEN_BITS]) begin
                ctl_next.mode         = bvls_pkg::MODE_OVERFLOW;
                ctl_next.answer_given = 1'b1;
              end else if (slen == '0) begin
                finish = 1'b1;
              end else begin
                ctl_next.mode = bvls_pkg::MODE_STR_BODY;
              end
            end else if (is_digit) begin
              if (slen_x10_ovf) begin
                ctl_next.mode         = bvls_pkg::MODE_OVERFLOW;
                ctl_next.answer_given = 1'b1;
              end else begin
                slen_next = slen_x10[LEN_BITS-1:0];
              end
            end else begin
              ctl_next.mode         = bvls_pkg::MODE_BAD_TYPE;
              ctl_next.answer_given = 1'b1;
            end
          end
          bvls_pkg::MODE_STR_BODY: begin
            slen_next = slen_dec;
            if (slen_dec == '0) begin
              finish = 1'b1;
            end
          end
          default: begin
            ctl_next.mode         = bvls_pkg::MODE_BAD_TYPE;
            ctl_next.answer_given = 1'b1;
          end
        endcase
        // a value closed: top level ends the scan, nested one starts a sibling
        if (finish) begin
          ctl_next.mode = (finish_depth == '0) ? bvls_pkg::MODE_DONE
                                               : bvls_pkg::MODE_VALUE_START;
          if (finish_depth == '0) begin
            ctl_next.answer_given = 1'b1;
          end
        end
      end
    end
  end

  assign pos_wide = {32'b0, pos_next};

  always_comb begin
    value_length = '0;
    unique case (ctl_next.mode)
      bvls_pkg::MODE_DONE: begin
        status       = bvls_pkg::STATUS_COMPLETE;
        value_length = pos_wide[31:0];
      end
      bvls_pkg::MODE_BAD_TYPE: status = bvls_pkg::STATUS_BAD_TYPE;
      bvls_pkg::MODE_OVERFLOW: status = bvls_pkg::STATUS_OVERFLOW;
      default:                 status = bvls_pkg::STATUS_TRUNCATED;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/bencode_value_length_scanner.sv
// ----------------------------------------------------------------------------
// bencode_value_length_scanner: byte length of the first bencoded value
//
// usage
//   in_bytes carries one payload word per handshake: data_byte and last_byte,
//   last_byte marking the final byte of the payload. results carries one word
//   per payload, value_length and status, handed over with valid/ready.
//   status: complete, bad type byte, truncated, or depth/length overflow;
//   value_length is zero unless the value completed.
//   an accepted byte lands in an input register and is scanned from there; a
//   last byte waits for a free result register to take its word. throughput
//   is one byte per cycle while no last byte waits: the scan state update is
//   a single pass of compare, add and shift logic between the input and state
//   registers. bytes after the value are consumed and ignored until last_byte.
//   when results stalls, the result register holds its word; bytes still flow
//   until a second last byte reaches the scanner, which then waits for the
//   result register to drain, and in_bytes.ready drops once that backs up.
//   rst (synchronous) empties both registers and returns the scan state to
//   the start of a payload; after the last byte the state returns there too.
// ----------------------------------------------------------------------------
`default_nettype none

module bencode_value_length_scanner #(
  parameter int MAX_DEPTH = 64,
  parameter int LEN_BITS  = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bvls_in_if.sink    in_bytes,
  bvls_out_if.source results
);

  // depth counter must hold MAX_DEPTH itself
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  // input register
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;

  // scan state
  bvls_pkg::scan_ctl_t   ctl;
  logic [DEPTH_W-1:0]    depth;
  logic [LEN_BITS-1:0]   slen;
  logic [LEN_BITS-1:0]   pos;

  // next state from the scanner
  bvls_pkg::scan_ctl_t   ctl_next;
  logic [DEPTH_W-1:0]    depth_next;
  logic [LEN_BITS-1:0]   slen_next;
  logic [LEN_BITS-1:0]   pos_next;
  logic [31:0]           length_next;
  logic [1:0]            status_next;

  // result register
  logic        out_valid;
  logic [31:0] out_length;
  logic [1:0]  out_status;

  logic out_free;
  logic scan_go;
  logic in_take;

  // result slot frees up this cycle if empty or being taken
  assign out_free = !out_valid || results.ready;
  // a buffered byte is scanned unless it ends a payload and the slot is full
  assign scan_go  = in_valid && (!in_last || out_free);
  assign in_bytes.ready = !in_valid || scan_go;
  assign in_take  = in_bytes.valid && in_bytes.ready;

  bvls_next #(
    .MAX_DEPTH (MAX_DEPTH),
    .LEN_BITS  (LEN_BITS),
    .DEPTH_W   (DEPTH_W)
  ) u_next (
    .ctl          (ctl),
    .depth        (depth),
    .slen         (slen),
    .pos          (pos),
    .data_byte    (in_data),
    .ctl_next     (ctl_next),
    .depth_next   (depth_next),
    .slen_next    (slen_next),
    .pos_next     (pos_next),
    .value_length (length_next),
    .status       (status_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_bytes.ready) begin
      in_valid <= in_bytes.valid;
    end
    if (in_take) begin
      in_data <= in_bytes.data_byte;
      in_last <= in_bytes.last_byte;
    end
  end

  // scan state: back to payload start after the last byte
  always_ff @(posedge clk) begin
    if (rst || (scan_go && in_last)) begin
      ctl.mode         <= bvls_pkg::MODE_VALUE_START;
      ctl.answer_given <= 1'b0;
      depth            <= '0;
      slen             <= '0;
      pos              <= '0;
    end else if (scan_go) begin
      ctl   <= ctl_next;
      depth <= depth_next;
      slen  <= slen_next;
      pos   <= pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_go && in_last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (scan_go && in_last) begin
      out_length <= length_next;
      out_status <= status_next;
    end
  end

  assign results.valid        = out_valid;
  assign results.value_length = out_length;
  assign results.status       = out_status;

endmodule

`default_nettype wire

// File: bench/bencode_value_length_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bencode_value_length_scanner_tb: self-checking bench for the value scanner
// sends payloads byte by byte with random bursts and gaps while the result
// side stalls on its own pattern, with one long hold-off that backs up the
// input. a directed table covers delimiters, digit bounds, length and depth
// limits, bad type bytes and truncation. a random part follows, mostly
// well-formed nested values with random content, plus noise, truncated and
// corrupted payloads. a scan predictor checks every result word in order.
// ----------------------------------------------------------------------------

module bencode_value_length_scanner_tb;

  // block configuration, kept equal to the instance parameters
  localparam int MAX_DEPTH = 64;
  localparam int LEN_BITS = 32;
  localparam logic [63:0] LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;

  // run shape
  localparam int RANDOM_WORDS = 940;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STEADY_PAYLOADS = 10;
  localparam int DRAIN_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] length;
    logic [1:0]  status;
  } scan_result_t;

  // a directed row: payload text ('#' stands for a zero byte) and,
  // where it is obvious, the result typed in by hand
  typedef struct {
    string        text;
    bit           known;
    scan_result_t answer;
  } stim_row_t;

  typedef struct {
    bit           known;
    scan_result_t answer;
  } row_answer_t;

  logic clk;
  logic rst;

  bvls_in_if  in_bytes ();
  bvls_out_if results ();

  bencode_value_length_scanner #(
    .MAX_DEPTH(MAX_DEPTH),
    .LEN_BITS (LEN_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in_bytes(in_bytes),
    .results (results)
  );

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // scan predictor: own copy of the parse state, one call per accepted word
  // --------------------------------------------------------------------------
  logic [2:0]  scan_mode;
  int unsigned scan_depth;
  logic [63:0] scan_strlen;
  logic [63:0] scan_pos;
  bit          scan_settled;

  function automatic void clear_scan();
    scan_mode    = bvls_pkg::MODE_VALUE_START;
    scan_depth   = 0;
    scan_strlen  = '0;
    scan_pos     = '0;
    scan_settled = 1'b0;
  endfunction

  // outcome fixed, later bytes of the payload are ignored
  function automatic void settle_scan(input logic [2:0] mode);
    scan_mode    = mode;
    scan_settled = 1'b1;
  endfunction

  // a child or the top value just ended
  function automatic void close_value();
    if (scan_depth == 0) begin
      settle_scan(bvls_pkg::MODE_DONE);
    end else begin
      scan_mode = bvls_pkg::MODE_VALUE_START;
    end
  endfunction

  function automatic void scan_one_byte(input logic [7:0] b);
    logic [63:0] digit;
    logic        is_digit;
    digit    = {56'd0, b - bvls_pkg::CHAR_ZERO};
    is_digit = (b >= bvls_pkg::CHAR_ZERO) && (b <= bvls_pkg::CHAR_NINE);
    if (scan_pos >= LEN_MAX) begin
      settle_scan(bvls_pkg::MODE_OVERFLOW);
    end else begin
      scan_pos++;
      case (scan_mode)
        bvls_pkg::MODE_VALUE_START: begin
          if (b == bvls_pkg::CHAR_E) begin
            if (scan_depth == 0) begin
              settle_scan(bvls_pkg::MODE_BAD_TYPE);
            end else begin
              scan_depth--;
              close_value();
            end
          end else if (b == bvls_pkg::CHAR_I) begin
            scan_mode = bvls_pkg::MODE_INT_BODY;
          end else if (b == bvls_pkg::CHAR_L || b == bvls_pkg::CHAR_D) begin
            if (scan_depth >= MAX_DEPTH) begin
              settle_scan(bvls_pkg::MODE_OVERFLOW);
            end else begin
              scan_depth++;
            end
          end else if (is_digit) begin
            scan_strlen = digit;
            if (scan_strlen > LEN_MAX) begin
              settle_scan(bvls_pkg::MODE_OVERFLOW);
            end else begin
              scan_mode = bvls_pkg::MODE_LEN_DIGITS;
            end
          end else begin
            settle_scan(bvls_pkg::MODE_BAD_TYPE);
          end
        end
        bvls_pkg::MODE_INT_BODY: begin
          if (b == bvls_pkg::CHAR_E) begin
            close_value();
          end
        end
        bvls_pkg::MODE_LEN_DIGITS: begin
          if (b == bvls_pkg::CHAR_COLON) begin
            if (scan_strlen > LEN_MAX - scan_pos) begin
              settle_scan(bvls_pkg::MODE_OVERFLOW);
            end else if (scan_strlen == 0) begin
              close_value();
            end else begin
              scan_mode = bvls_pkg::MODE_STR_BODY;
            end
          end else if (is_digit) begin
            if (scan_strlen > (LEN_MAX - digit) / bvls_pkg::RADIX) begin
              settle_scan(bvls_pkg::MODE_OVERFLOW);
            end else begin
              scan_strlen = scan_strlen * bvls_pkg::RADIX + digit;
            end
          end else begin
            settle_scan(bvls_pkg::MODE_BAD_TYPE);
          end
        end
        bvls_pkg::MODE_STR_BODY: begin
          if (scan_strlen > 0) begin
            scan_strlen--;
          end
          if (scan_strlen == 0) begin
            close_value();
          end
        end
        default: begin
          settle_scan(bvls_pkg::MODE_BAD_TYPE);
        end
      endcase
    end
  endfunction

  // returns 1 with the result word when the word closes a payload
  function automatic bit predict_word(input logic [7:0] b, input logic last,
                                      output scan_result_t res);
    res = '0;
    if (!scan_settled) begin
      scan_one_byte(b);
    end
    if (!last) begin
      return 1'b0;
    end
    case (scan_mode)
      bvls_pkg::MODE_DONE: begin
        res.length = scan_pos[31:0];
        res.status = bvls_pkg::STATUS_COMPLETE;
      end
      bvls_pkg::MODE_BAD_TYPE: res.status = bvls_pkg::STATUS_BAD_TYPE;
      bvls_pkg::MODE_OVERFLOW: res.status = bvls_pkg::STATUS_OVERFLOW;
      default:                 res.status = bvls_pkg::STATUS_TRUNCATED;
    endcase
    clear_scan();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // monitor: predicts on accepted input words, checks accepted result words
  // --------------------------------------------------------------------------
  scan_result_t awaited_results[$];
  row_answer_t  row_answers[$];
  int           error_count = 0;

  initial clear_scan();

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    row_answer_t  typed;
    if (!rst) begin
      // result side first, a word can never come out on its own input edge
      if (results.valid && results.ready) begin
        got.length = results.value_length;
        got.status = results.status;
        if (awaited_results.size() == 0) begin
          $error("unexpected result word: value_length %0d status %0d",
                 got.length, got.status);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.length !== want.length) begin
            $error("value_length: expected %0d, got %0d", want.length, got.length);
            error_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
          end
        end
      end
      if (in_bytes.valid && in_bytes.ready) begin
        if (predict_word(in_bytes.data_byte, in_bytes.last_byte, want)) begin
          // directed rows with a hand-typed answer override the predictor
          if (row_answers.size() > 0) begin
            typed = row_answers.pop_front();
            if (typed.known) begin
              want = typed.answer;
            end
          end
          awaited_results.insert(awaited_results.size(), want);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: cycles with no handshake on either channel
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_bytes.valid && in_bytes.ready) || (results.valid && results.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // result side: stall styles picked at random from time to time, plus one
  // long hold-off on request so the block fills and stalls its input
  // --------------------------------------------------------------------------
  logic hold_request = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  int   style = 0;
  int   style_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      results.ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES;
    end else if (hold_left > 0) begin
      results.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      if (style_left == 0) begin
        style <= $urandom_range(0, 3);
        style_left <= $urandom_range(20, 150);
      end else begin
        style_left <= style_left - 1;
      end
      case (style)
        0: results.ready <= 1'b1;                          // no stalls
        1: results.ready <= 1'($urandom_range(0, 1));      // coin flip
        2: results.ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
        default: results.ready <= ~results.ready;          // alternating
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sender: bursts of random length, random gaps, junk on the bus while idle
  // --------------------------------------------------------------------------
  int burst_left = 0;
  bit steady_sender = 1'b0;

  task automatic send_word(input logic [7:0] b, input logic last);
    in_bytes.valid     <= 1'b1;
    in_bytes.data_byte <= b;
    in_bytes.last_byte <= last;
    @(posedge clk);
    while (!in_bytes.ready) @(posedge clk);
    if (!steady_sender) begin
      if (burst_left == 0) begin
        in_bytes.valid     <= 1'b0;
        in_bytes.data_byte <= 8'($urandom);
        in_bytes.last_byte <= 1'($urandom);
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // payload builder for the random part
  // --------------------------------------------------------------------------
  logic [7:0] payload[$];

  function automatic void append_byte(input logic [7:0] b);
    payload.insert(payload.size(), b);
  endfunction

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) append_byte(s[k]);
  endtask

  task automatic make_payload();
    int          kind;
    int          open;
    int          n;
    int          pick;
    logic [7:0]  b;
    logic [63:0] declared;
    payload.delete();
    open = 0;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      // plain noise
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
    end else if (kind < 10) begin
      // nesting right around the depth limit
      n = $urandom_range(MAX_DEPTH - 4, MAX_DEPTH + 2);
      repeat (n) append_byte($urandom_range(0, 1) ? bvls_pkg::CHAR_L : bvls_pkg::CHAR_D);
      push_text("i0e");
      repeat (n) append_byte(bvls_pkg::CHAR_E);
    end else if (kind < 14) begin
      // declared string lengths near and above the length limit
      case ($urandom_range(0, 2))
        0: declared = LEN_MAX - 64'($urandom_range(0, 24));
        1: declared = LEN_MAX + 64'd1 + 64'($urandom_range(0, 1000));
        default: declared = {32'd0, $urandom};
      endcase
      push_text($sformatf("%0d", declared));
      append_byte(bvls_pkg::CHAR_COLON);
      repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
    end else begin
      // well-formed value with random content, lists and dicts nested
      do begin
        if (open > 0 && ($urandom_range(0, 2) == 0 || payload.size() > 40)) begin
          append_byte(bvls_pkg::CHAR_E);
          open--;
        end else begin
          pick = (payload.size() > 40) ? $urandom_range(0, 1) : $urandom_range(0, 3);
          case (pick)
            0: begin
              append_byte(bvls_pkg::CHAR_I);
              repeat ($urandom_range(0, 4)) begin
                do b = 8'($urandom); while (b == bvls_pkg::CHAR_E);
                append_byte(b);
              end
              append_byte(bvls_pkg::CHAR_E);
            end
            1: begin
              n = $urandom_range(0, 6);
              if ($urandom_range(0, 7) == 0) begin
                append_byte(bvls_pkg::CHAR_ZERO);      // leading zero in the length
              end
              push_text($sformatf("%0d", n));
              append_byte(bvls_pkg::CHAR_COLON);
              repeat (n) append_byte(8'($urandom));
            end
            default: begin
              append_byte(pick == 2 ? bvls_pkg::CHAR_L : bvls_pkg::CHAR_D);
              open++;
            end
          endcase
        end
      end while (open > 0);
      // damage some of them
      pick = $urandom_range(0, 99);
      if (pick < 15 && payload.size() > 1) begin
        n = $urandom_range(1, payload.size() - 1);
        while (payload.size() > n) void'(payload.pop_back());
      end else if (pick < 25) begin
        payload[$urandom_range(0, payload.size() - 1)] = 8'($urandom);
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 5)) append_byte(8'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  stim_row_t rows[$];

  task automatic add_row(input string text, input bit known,
                         input logic [31:0] length, input logic [1:0] status);
    stim_row_t r;
    r.text          = text;
    r.known         = known;
    r.answer.length = length;
    r.answer.status = status;
    rows.insert(rows.size(), r);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    string       deep;
    string       closers;
    row_answer_t ra;
    logic [7:0]  c;
    int          random_words;
    int          payload_count;

    rst = 1'b1;
    in_bytes.valid     = 1'b0;
    in_bytes.data_byte = '0;
    in_bytes.last_byte = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    deep = "";
    closers = "";
    repeat (MAX_DEPTH) begin
      deep    = {deep, "l"};
      closers = {closers, "e"};
    end

    // complete values of every kind
    add_row("i42e",        1'b1, 32'd4, bvls_pkg::STATUS_COMPLETE);
    add_row("i-7eXY",      1'b1, 32'd4, bvls_pkg::STATUS_COMPLETE); // trailing bytes ignored
    add_row("ie",          1'b1, 32'd2, bvls_pkg::STATUS_COMPLETE); // empty integer body
    add_row("0:",          1'b1, 32'd2, bvls_pkg::STATUS_COMPLETE); // empty string
    add_row("9:123456789", 1'b1, 32'd11, bvls_pkg::STATUS_COMPLETE);
    add_row("003:abc",     1'b1, 32'd7, bvls_pkg::STATUS_COMPLETE); // leading zeros
    add_row("1:e",         1'b1, 32'd3, bvls_pkg::STATUS_COMPLETE);
    add_row("le",          1'b1, 32'd2, bvls_pkg::STATUS_COMPLETE);
    add_row("d3:keyi1ee",  1'b0, '0, '0);
    add_row("lleeee",      1'b0, '0, '0);                   // extra closers ignored
    add_row("dli5e0:ee2:zz", 1'b0, '0, '0);
    add_row({deep, "i1e", closers}, 1'b0, '0, '0);          // exactly at the depth limit
    // bad type bytes
    add_row("e",           1'b1, '0, bvls_pkg::STATUS_BAD_TYPE);  // closer at top level
    add_row("x123",        1'b1, '0, bvls_pkg::STATUS_BAD_TYPE);
    add_row("#",           1'b1, '0, bvls_pkg::STATUS_BAD_TYPE);  // zero byte
    add_row("\377",        1'b1, '0, bvls_pkg::STATUS_BAD_TYPE);  // all-ones byte
    add_row("/",           1'b1, '0, bvls_pkg::STATUS_BAD_TYPE);  // just below the digits
    add_row(":",           1'b1, '0, bvls_pkg::STATUS_BAD_TYPE);  // just above the digits
    add_row("12a:",        1'b1, '0, bvls_pkg::STATUS_BAD_TYPE);  // non-digit in length
    // truncated payloads
    add_row("i12",         1'b1, '0, bvls_pkg::STATUS_TRUNCATED);
    add_row("l",           1'b1, '0, bvls_pkg::STATUS_TRUNCATED);
    add_row("5:ab",        1'b1, '0, bvls_pkg::STATUS_TRUNCATED);
    add_row("4294967284:", 1'b1, '0, bvls_pkg::STATUS_TRUNCATED); // largest length that fits
    // length and depth overflow
    add_row("4294967285:", 1'b1, '0, bvls_pkg::STATUS_OVERFLOW);  // length plus position
    add_row("4294967296:", 1'b1, '0, bvls_pkg::STATUS_OVERFLOW);  // length itself too big
    add_row({deep, "lee"}, 1'b1, '0, bvls_pkg::STATUS_OVERFLOW);  // one level too deep

    foreach (rows[i]) begin
      ra.known  = rows[i].known;
      ra.answer = rows[i].answer;
      row_answers.insert(row_answers.size(), ra);
      for (int k = 0; k < rows[i].text.len(); k++) begin
        c = rows[i].text[k];
        if (c == "#") c = 8'h00;
        send_word(c, k == rows[i].text.len() - 1);
      end
    end

    // random part; the first payloads go back to back while the result
    // side holds off, so the block backs up and drops its input ready
    hold_request <= 1'b1;
    steady_sender = 1'b1;
    random_words = 0;
    payload_count = 0;
    while (random_words < RANDOM_WORDS) begin
      make_payload();
      payload_count++;
      if (payload_count > STEADY_PAYLOADS) steady_sender = 1'b0;
      for (int k = 0; k < payload.size(); k++) begin
        send_word(payload[k], k == payload.size() - 1);
        random_words++;
      end
    end
    in_bytes.valid <= 1'b0;

    // drain, then keep watching to catch stray result words
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
sv/bvls_pkg.sv
sv/bvls_if.sv
sv/bvls_next.sv
sv/bencode_value_length_scanner.sv
bench/bencode_value_length_scanner_tb.sv
